/* rtl/point_cloud_voxel_assigner_macros.svh */
// Assertion macros shared by the voxel assigner RTL
`ifndef POINT_CLOUD_VOXEL_ASSIGNER_MACROS_SVH
`define POINT_CLOUD_VOXEL_ASSIGNER_MACROS_SVH

// Check a property on every clock edge outside reset
`define PCVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define PCVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/pcva_pkg.sv */
// Shared types, constants and codes of the voxel assigner
package pcva_pkg;

  localparam int DEF_TABLE_DEPTH  = 16384;
  localparam int DEF_VOXEL_POINTS = 32;
  localparam int DEF_AXIS_BITS    = 12;

  localparam int COORD_W   = 32;
  localparam int POINT_W   = 4 * COORD_W;
  localparam int SIZE_W    = 31;
  localparam int DIMS_W    = 36;
  localparam int MAXV_W    = 15;
  localparam int DIV_W     = COORD_W + 1;
  localparam int STEP_W    = 6;

  localparam int STATUS_W  = 3;
  localparam int VIDX_OUT_W = 14;
  localparam int SLOT_OUT_W = 5;
  localparam int GRID_OUT_W = 12;
  localparam int USED_OUT_W = 15;
  localparam int OUT_DATA_W = 200;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_MIN_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_Z   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_X  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_Y  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_Z  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DIMS    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MAX_VOX = 3'd7;

  typedef enum logic [STATUS_W-1:0] {
    ST_OUTSIDE    = 3'd0,
    ST_NEW        = 3'd1,
    ST_APPEND     = 3'd2,
    ST_FULL       = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] min_z;
    logic [SIZE_W-1:0]  size_x;
    logic [SIZE_W-1:0]  size_y;
    logic [SIZE_W-1:0]  size_z;
    logic [DIMS_W-1:0]  dims;
    logic [MAXV_W-1:0]  vox_limit;
  } cfg_t;

endpackage

/* rtl/pcva_ram.sv */
// Generic single-port-write, registered-read RAM
module pcva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/pcva_front.sv */
// Front end: grid index of each axis by restoring division, bounds check, key
module pcva_front #(
  parameter int AXIS_BITS = pcva_pkg::DEF_AXIS_BITS,
  parameter int KEY_W = 3 * AXIS_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcva_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_frame,
  input  logic [pcva_pkg::POINT_W-1:0]  in_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_frame,
  output logic                          out_inside,
  output logic [KEY_W-1:0]              out_key,
  output logic [pcva_pkg::POINT_W-1:0]  out_point
);
  import pcva_pkg::*;

  front_state_t state_r, state_nxt;
  logic                    frame_r;
  logic [POINT_W-1:0]      pt_r;
  logic [2:0][DIV_W-1:0]   q_r, q_nxt;
  logic [2:0][COORD_W-1:0] rem_r, rem_nxt;
  logic [2:0]              neg_r, neg_nxt;
  logic [STEP_W-1:0]       cnt_r, cnt_nxt;

  logic [2:0][COORD_W-1:0] mins;
  logic [2:0][SIZE_W-1:0]  sizes;
  logic [KEY_W-1:0]        dims_ext;
  logic [2:0]              axis_ok;
  logic [KEY_W-1:0]        key;

  assign mins     = {cfg.min_z, cfg.min_y, cfg.min_x};
  assign sizes    = {cfg.size_z, cfg.size_y, cfg.size_x};
  assign dims_ext = KEY_W'(cfg.dims);

  wire accept   = in_valid && in_ready;
  wire last_step = (cnt_r == STEP_W'(DIV_W - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: if (in_valid) state_nxt = FR_DIV;
      FR_DIV:  if (last_step) state_nxt = FR_PUSH;
      FR_PUSH: if (out_ready) state_nxt = FR_IDLE;
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    logic [DIV_W-1:0] diff;
    logic [DIV_W-1:0] rem_sh;
    logic             ge;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    for (int a = 0; a < 3; a++) begin
      diff   = {in_point[a*COORD_W+COORD_W-1], in_point[a*COORD_W +: COORD_W]} -
               {mins[a][COORD_W-1], mins[a]};
      rem_sh = {rem_r[a], q_r[a][DIV_W-1]};
      ge     = (rem_sh >= DIV_W'(sizes[a]));
      if (state_r == FR_IDLE) begin
        neg_nxt[a] = diff[DIV_W-1];
        q_nxt[a]   = diff[DIV_W-1] ? (~diff + DIV_W'(1)) : diff;
        rem_nxt[a] = '0;
      end else if (state_r == FR_DIV) begin
        rem_nxt[a] = ge ? COORD_W'(rem_sh - DIV_W'(sizes[a])) : rem_sh[COORD_W-1:0];
        q_nxt[a]   = {q_r[a][DIV_W-2:0], ge};
      end
    end
    if (state_r == FR_IDLE) begin
      cnt_nxt = '0;
    end else if (state_r == FR_DIV) begin
      cnt_nxt = cnt_r + STEP_W'(1);
    end
  end

  // Negative offsets less than one voxel deep truncate to index zero
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_ok[a] = (sizes[a] != '0) && (!neg_r[a] || (q_r[a] == '0)) &&
                   (q_r[a] < DIV_W'(dims_ext[a*AXIS_BITS +: AXIS_BITS]));
    end
    key = '0;
    if (&axis_ok) begin
      for (int a = 0; a < 3; a++) begin
        key[a*AXIS_BITS +: AXIS_BITS] = neg_r[a] ? '0 : q_r[a][AXIS_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_r <= in_frame;
      pt_r    <= in_point;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign in_ready   = (state_r == FR_IDLE);
  assign out_valid  = (state_r == FR_PUSH);
  assign out_frame  = frame_r;
  assign out_inside = &axis_ok;
  assign out_key    = key;
  assign out_point  = pt_r;

endmodule

/* rtl/pcva_queue.sv */
// Two-entry queue between front and back
module pcva_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  `include "point_cloud_voxel_assigner_macros.svh"

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;

  wire push = push_valid && push_ready;
  wire pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];

  `PCVA_ASSERT(a_count_bound, count_r <= 2'd2, "queue count out of range")
  `PCVA_ASSERT(a_ptr_match, (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r), "queue pointers disagree with count")

endmodule

/* rtl/pcva_back.sv */
// Back end: voxel table scan, create or append, result register
module pcva_back #(
  parameter int TABLE_DEPTH  = pcva_pkg::DEF_TABLE_DEPTH,
  parameter int VOXEL_POINTS = pcva_pkg::DEF_VOXEL_POINTS,
  parameter int AXIS_BITS    = pcva_pkg::DEF_AXIS_BITS,
  parameter int KEY_W  = 3 * AXIS_BITS,
  parameter int VIDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  parameter int TOT_W  = $clog2(TABLE_DEPTH + 1),
  parameter int CNT_W  = $clog2(VOXEL_POINTS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [pcva_pkg::MAXV_W-1:0]     vox_limit,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic                            item_frame,
  input  logic                            item_inside,
  input  logic [KEY_W-1:0]                item_key,
  input  logic [pcva_pkg::POINT_W-1:0]    item_point,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pcva_pkg::STATUS_W-1:0]   out_status,
  output logic [pcva_pkg::OUT_DATA_W-1:0] out_data
);
  import pcva_pkg::*;
  `include "point_cloud_voxel_assigner_macros.svh"

  back_state_t state_r, state_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [TOT_W-1:0]   issue_r, issue_nxt;
  logic [VIDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic               inflight_r, inflight_nxt;
  logic [KEY_W-1:0]   key_r;
  logic [POINT_W-1:0] pt_r;
  status_t            res_status_r, res_status_nxt;
  logic [VIDX_W-1:0]  res_vidx_r, res_vidx_nxt;
  logic [CNT_W-1:0]   res_slot_r, res_slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic               coord_we, fill_we;
  logic [VIDX_W-1:0]  fill_waddr;
  logic [CNT_W-1:0]   fill_wdata;
  logic [KEY_W-1:0]   coord_rd;
  logic [CNT_W-1:0]   fill_rd;

  wire pop      = item_valid && item_ready;
  wire hit      = inflight_r && (coord_rd == key_r);
  wire more     = (issue_r < total_r);
  wire miss     = !hit && !inflight_r && !more;
  wire can_new  = (32'(total_r) < 32'(vox_limit)) && (32'(total_r) < TABLE_DEPTH);
  wire can_add  = (32'(fill_rd) < VOXEL_POINTS);
  wire out_load = (state_r == BK_OUT) && (!out_valid_r || out_ready);

  pcva_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH), .ADDR_W(VIDX_W)) u_coord_ram (
    .clk   (clk),
    .we    (coord_we),
    .waddr (total_r[VIDX_W-1:0]),
    .wdata (key_r),
    .raddr (issue_r[VIDX_W-1:0]),
    .rdata (coord_rd)
  );

  pcva_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_DEPTH), .ADDR_W(VIDX_W)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (issue_r[VIDX_W-1:0]),
    .rdata (fill_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (item_valid) state_nxt = item_inside ? BK_SCAN : BK_OUT;
      BK_SCAN: if (hit || miss) state_nxt = BK_OUT;
      BK_OUT:  if (out_load) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    total_nxt      = total_r;
    issue_nxt      = issue_r;
    cmp_idx_nxt    = cmp_idx_r;
    inflight_nxt   = inflight_r;
    res_status_nxt = res_status_r;
    res_vidx_nxt   = res_vidx_r;
    res_slot_nxt   = res_slot_r;
    coord_we       = 1'b0;
    fill_we        = 1'b0;
    fill_waddr     = cmp_idx_r;
    fill_wdata     = fill_rd + CNT_W'(1);
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    case (state_r)
      BK_IDLE: begin
        issue_nxt      = '0;
        inflight_nxt   = 1'b0;
        res_status_nxt = ST_OUTSIDE;
        res_vidx_nxt   = '0;
        res_slot_nxt   = '0;
        if (item_valid && item_frame) total_nxt = '0;
      end
      BK_SCAN: begin
        if (hit) begin
          if (can_add) begin
            res_status_nxt = ST_APPEND;
            res_vidx_nxt   = cmp_idx_r;
            res_slot_nxt   = fill_rd;
            fill_we        = 1'b1;
          end else begin
            res_status_nxt = ST_FULL;
          end
        end else if (more) begin
          issue_nxt    = issue_r + TOT_W'(1);
          cmp_idx_nxt  = issue_r[VIDX_W-1:0];
          inflight_nxt = 1'b1;
        end else if (inflight_r) begin
          inflight_nxt = 1'b0;
        end else if (can_new) begin
          res_status_nxt = ST_NEW;
          res_vidx_nxt   = total_r[VIDX_W-1:0];
          coord_we       = 1'b1;
          fill_we        = 1'b1;
          fill_waddr     = total_r[VIDX_W-1:0];
          fill_wdata     = CNT_W'(1);
          total_nxt      = total_r + TOT_W'(1);
        end else begin
          res_status_nxt = ST_TABLE_FULL;
        end
      end
      BK_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {
            2'b00,
            USED_OUT_W'(total_r),
            pt_r,
            GRID_OUT_W'(key_r[2*AXIS_BITS +: AXIS_BITS]),
            GRID_OUT_W'(key_r[AXIS_BITS +: AXIS_BITS]),
            GRID_OUT_W'(key_r[0 +: AXIS_BITS]),
            SLOT_OUT_W'(res_slot_r),
            VIDX_OUT_W'(res_vidx_r)
          };
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      total_r     <= '0;
      inflight_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      inflight_r  <= inflight_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      key_r <= item_key;
      pt_r  <= item_point;
    end
    if (out_load) out_status_r <= res_status_r;
    issue_r      <= issue_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_vidx_r   <= res_vidx_nxt;
    res_slot_r   <= res_slot_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign item_ready = (state_r == BK_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;

  `PCVA_ASSERT(a_total_bound, 32'(total_r) <= TABLE_DEPTH, "voxel count above table depth")
  `PCVA_ASSERT(a_cmp_in_range, (state_r == BK_SCAN && inflight_r) |-> (32'(cmp_idx_r) < 32'(total_r)), "compare index beyond filled table")
  `PCVA_ASSERT(a_new_grows, (state_r == BK_SCAN && miss && can_new) |=> (total_r == $past(total_r) + TOT_W'(1)), "new voxel did not advance count")
  `PCVA_ASSERT(a_out_from_back, $rose(out_valid_r) |-> $past(state_r == BK_OUT), "result raised outside output state")

endmodule

/* rtl/point_cloud_voxel_assigner.sv */
// Top level: configuration registers, front, queue and back of the voxel assigner
// Flow: the front accepts a point, runs 33 division steps and pushes the result; the back
//   pops it, scans up to voxels_used table entries at one per cycle, and loads the output
//   register. The front takes no new point until it has pushed the last, nor the back
//   until its result is loaded; the queue lets the two overlap. The table scan in the back
//   (one RAM read per cycle) and the bit-serial divider in the front set the pace.
// Reset: synchronous, active low; clears control, voxel count and registers to defaults.
//   Table contents are not cleared: only entries below the voxel count are ever read.
module point_cloud_voxel_assigner #(
  parameter int TABLE_DEPTH  = pcva_pkg::DEF_TABLE_DEPTH,
  parameter int VOXEL_POINTS = pcva_pkg::DEF_VOXEL_POINTS,
  parameter int AXIS_BITS    = pcva_pkg::DEF_AXIS_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // point_x[31:0], point_y[63:32], point_z[95:64], point_feature[127:96]
  input  logic [pcva_pkg::POINT_W-1:0]    in_tdata,
  // frame_start[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // voxel_index[13:0], slot_index[18:14], grid_x[30:19], grid_y[42:31], grid_z[54:43],
  // out_x[86:55], out_y[118:87], out_z[150:119], out_feature[182:151],
  // voxels_used[197:183], zero[199:198]
  output logic [pcva_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[2:0]
  output logic [pcva_pkg::STATUS_W-1:0]   out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pcva_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pcva_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pcva_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import pcva_pkg::*;

  localparam int KEY_W  = 3 * AXIS_BITS;
  localparam int ITEM_W = 2 + KEY_W + POINT_W;

  cfg_t cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;

  logic              fr_valid, fr_ready, fr_frame, fr_inside;
  logic [KEY_W-1:0]  fr_key;
  logic [POINT_W-1:0] fr_point;
  logic              bk_valid, bk_ready;
  logic [ITEM_W-1:0] bk_item;

  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1 -: REG_IDX_W];
  assign cfg_pready = 1'b1;
  wire cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_x     <= '0;
      cfg_r.min_y     <= '0;
      cfg_r.min_z     <= '0;
      cfg_r.size_x    <= SIZE_W'(65536);
      cfg_r.size_y    <= SIZE_W'(65536);
      cfg_r.size_z    <= SIZE_W'(65536);
      cfg_r.dims      <= '0;
      cfg_r.vox_limit <= MAXV_W'(16384);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_MIN_X:   cfg_r.min_x     <= cfg_pwdata[COORD_W-1:0];
        REG_MIN_Y:   cfg_r.min_y     <= cfg_pwdata[COORD_W-1:0];
        REG_MIN_Z:   cfg_r.min_z     <= cfg_pwdata[COORD_W-1:0];
        REG_SIZE_X:  cfg_r.size_x    <= cfg_pwdata[SIZE_W-1:0];
        REG_SIZE_Y:  cfg_r.size_y    <= cfg_pwdata[SIZE_W-1:0];
        REG_SIZE_Z:  cfg_r.size_z    <= cfg_pwdata[SIZE_W-1:0];
        REG_DIMS:    cfg_r.dims      <= cfg_pwdata[DIMS_W-1:0];
        REG_MAX_VOX: cfg_r.vox_limit <= cfg_pwdata[MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_X:   cfg_prdata = CFG_DATA_W'(cfg_r.min_x);
      REG_MIN_Y:   cfg_prdata = CFG_DATA_W'(cfg_r.min_y);
      REG_MIN_Z:   cfg_prdata = CFG_DATA_W'(cfg_r.min_z);
      REG_SIZE_X:  cfg_prdata = CFG_DATA_W'(cfg_r.size_x);
      REG_SIZE_Y:  cfg_prdata = CFG_DATA_W'(cfg_r.size_y);
      REG_SIZE_Z:  cfg_prdata = CFG_DATA_W'(cfg_r.size_z);
      REG_DIMS:    cfg_prdata = CFG_DATA_W'(cfg_r.dims);
      REG_MAX_VOX: cfg_prdata = CFG_DATA_W'(cfg_r.vox_limit);
      default:     cfg_prdata = '0;
    endcase
  end

  pcva_front #(.AXIS_BITS(AXIS_BITS), .KEY_W(KEY_W)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_frame   (in_tuser),
    .in_point   (in_tdata),
    .out_valid  (fr_valid),
    .out_ready  (fr_ready),
    .out_frame  (fr_frame),
    .out_inside (fr_inside),
    .out_key    (fr_key),
    .out_point  (fr_point)
  );

  pcva_queue #(.WIDTH(ITEM_W)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  ({fr_frame, fr_inside, fr_key, fr_point}),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_item)
  );

  pcva_back #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .VOXEL_POINTS (VOXEL_POINTS),
    .AXIS_BITS    (AXIS_BITS),
    .KEY_W        (KEY_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .vox_limit   (cfg_r.vox_limit),
    .item_valid  (bk_valid),
    .item_ready  (bk_ready),
    .item_frame  (bk_item[ITEM_W-1]),
    .item_inside (bk_item[ITEM_W-2]),
    .item_key    (bk_item[POINT_W +: KEY_W]),
    .item_point  (bk_item[POINT_W-1:0]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_tuser),
    .out_data    (out_tdata)
  );

endmodule
